@@ rtl/supersampled_split_circle_pixel_unit_macros.svh @@
// Assertion macros for the circle pixel unit.
`ifndef SUPERSAMPLED_SPLIT_CIRCLE_PIXEL_UNIT_MACROS_SVH
`define SUPERSAMPLED_SPLIT_CIRCLE_PIXEL_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define SSCP_ASSERT_IMP(lbl, clk_i, rstn_i, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
		else $error("sscp assertion failed");
`define SSCP_ASSERT_NXT(lbl, clk_i, rstn_i, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) \
		else $error("sscp assertion failed");
`else
`define SSCP_ASSERT_IMP(lbl, clk_i, rstn_i, ante, cons)
`define SSCP_ASSERT_NXT(lbl, clk_i, rstn_i, ante, cons)
`endif

`endif

@@ rtl/sscp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package sscp_pkg;

	localparam int SUBS      = 4;
	localparam int NSAMP     = SUBS * SUBS;
	localparam int MIN_SIZE  = 4;
	localparam int MAX_SIZE  = 256;
	localparam int RST_SIZE  = 16;

	localparam int SIZE_W    = 9;
	localparam int NSQ_W     = 17;
	localparam int COORD_W   = 8;
	localparam int FINE_W    = 11;
	localparam int D_W       = 12;
	localparam int SQ_W      = 22;
	localparam int SUM_W     = 23;
	localparam int PROD_W    = 33;
	localparam int LIM_W     = 30;
	localparam int CNT_W     = 5;
	localparam int CH_W      = 8;
	localparam int NUM_W     = 13;
	localparam int RCP_W     = 17;
	localparam int RCP_SH    = 16;
	localparam int ARGB_W    = 32;

	localparam int LIMIT_K   = 8464;
	localparam int AREA_K    = 625;
	localparam int ALPHA_K   = 255;

	localparam int COV_STG   = 6;
	localparam int NSTG      = 8;

	typedef enum logic [0:0] {
		REG_IMAGE_SIZE = 1'b0,
		REG_ENABLED    = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [CH_W-1:0] r;
		logic [CH_W-1:0] g;
		logic [CH_W-1:0] b;
	} rgb_t;

	localparam rgb_t PAL_L_ON  = '{r: 8'd0,   g: 8'd120, b: 8'd215};
	localparam rgb_t PAL_R_ON  = '{r: 8'd250, g: 8'd250, b: 8'd250};
	localparam rgb_t PAL_L_OFF = '{r: 8'd110, g: 8'd110, b: 8'd110};
	localparam rgb_t PAL_R_OFF = '{r: 8'd175, g: 8'd175, b: 8'd175};

	// ceil(2^16 / t); exact quotient for numerators up to 4000
	localparam logic [RCP_W-1:0] RECIP_TAB [0:NSAMP] = '{
		17'd0,    17'd65536, 17'd32768, 17'd21846, 17'd16384, 17'd13108,
		17'd10923, 17'd9363, 17'd8192,  17'd7282,  17'd6554,  17'd5958,
		17'd5462, 17'd5042,  17'd4682,  17'd4370,  17'd4096
	};

	typedef struct packed {
		logic [COV_STG-1:0] adv;
	} cov_ctl_t;

endpackage
`default_nettype wire

@@ rtl/supersampled_split_circle_pixel_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Pipeline: every stage from input transaction to result on m_tdata is registered.
// Throughput: one pixel per cycle while m_tready is high; each stage advances when the next one is free.
// Stall: m_tready low holds results and backpressures stage by stage.
// Reset (arst_n low, asynchronous): pipeline empty, image_size 16, enabled 1.
`include "supersampled_split_circle_pixel_unit_macros.svh"
module supersampled_split_circle_pixel_unit (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic                         cfg_index,
	input  wire logic [sscp_pkg::SIZE_W-1:0]  cfg_data,
	input  wire logic                         s_tvalid,
	output logic                              s_tready,
	// pixel_x [7:0], pixel_y [15:8]
	input  wire logic [15:0]                  s_tdata,
	output logic                              m_tvalid,
	input  wire logic                         m_tready,
	// argb [31:0]
	output logic      [sscp_pkg::ARGB_W-1:0]  m_tdata
);
	import sscp_pkg::*;

	logic [SIZE_W-1:0]  size_q, size_d;
	logic [NSQ_W-1:0]   nsq_q;
	logic               enabled_q;

	logic [NSTG-1:0]    vld_q;
	logic [NSTG-1:0]    en;
	cov_ctl_t           cov_ctl;

	logic [CNT_W-1:0]   nl_s6, nr_s6;
	logic [NUM_W-1:0]   rnum_s7, gnum_s7, bnum_s7;
	logic [CNT_W-1:0]   tot_s7;
	logic [CH_W-1:0]    alpha_s7;
	logic [ARGB_W-1:0]  argb_s8;

	rgb_t               pl, pr;
	logic [NUM_W-1:0]   rnum_d, gnum_d, bnum_d;
	logic [CNT_W-1:0]   tot_d;
	logic [NUM_W-1:0]   anum_d;
	logic [CH_W-1:0]    rq_d, gq_d, bq_d;

	function automatic logic [NUM_W-1:0] blend_num(
		input logic [CH_W-1:0]  a,
		input logic [CH_W-1:0]  b,
		input logic [CNT_W-1:0] nl,
		input logic [CNT_W-1:0] nr
	);
		return NUM_W'(a) * NUM_W'(nl) + NUM_W'(b) * NUM_W'(nr);
	endfunction

	function automatic logic [CH_W-1:0] quot(
		input logic [NUM_W-1:0] num,
		input logic [RCP_W-1:0] rcp
	);
		logic [NUM_W+RCP_W-1:0] p;
		p = (NUM_W+RCP_W)'(num) * (NUM_W+RCP_W)'(rcp);
		return p[RCP_SH +: CH_W];
	endfunction

	always_comb begin
		if (cfg_data < SIZE_W'(MIN_SIZE)) begin
			size_d = SIZE_W'(MIN_SIZE);
		end else if (cfg_data > SIZE_W'(MAX_SIZE)) begin
			size_d = SIZE_W'(MAX_SIZE);
		end else begin
			size_d = cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q    <= SIZE_W'(RST_SIZE);
			nsq_q     <= NSQ_W'(RST_SIZE * RST_SIZE);
			enabled_q <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_IMAGE_SIZE: begin
					size_q <= size_d;
					nsq_q  <= NSQ_W'(size_d * size_d);
				end
				REG_ENABLED: begin
					enabled_q <= cfg_data[0];
				end
			endcase
		end
	end

	always_comb begin
		en[NSTG-1] = !vld_q[NSTG-1] || m_tready;
		for (int k = NSTG - 2; k >= 0; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	assign s_tready    = en[0];
	assign m_tvalid    = vld_q[NSTG-1];
	assign m_tdata     = argb_s8;
	assign cov_ctl.adv = en[COV_STG-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) begin
				vld_q[0] <= s_tvalid;
			end
			for (int k = 1; k < NSTG; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	sscp_cover u_cover (
		.clk     (clk),
		.ctl     (cov_ctl),
		.pixel_x (s_tdata[7:0]),
		.pixel_y (s_tdata[15:8]),
		.size_q  (size_q),
		.nsq_q   (nsq_q),
		.nl_s6   (nl_s6),
		.nr_s6   (nr_s6)
	);

	always_comb begin
		pl     = enabled_q ? PAL_L_ON : PAL_L_OFF;
		pr     = enabled_q ? PAL_R_ON : PAL_R_OFF;
		rnum_d = blend_num(pl.r, pr.r, nl_s6, nr_s6);
		gnum_d = blend_num(pl.g, pr.g, nl_s6, nr_s6);
		bnum_d = blend_num(pl.b, pr.b, nl_s6, nr_s6);
		tot_d  = nl_s6 + nr_s6;
		anum_d = NUM_W'(ALPHA_K) * NUM_W'(tot_d);
		rq_d   = quot(rnum_s7, RECIP_TAB[tot_s7]);
		gq_d   = quot(gnum_s7, RECIP_TAB[tot_s7]);
		bq_d   = quot(bnum_s7, RECIP_TAB[tot_s7]);
	end

	always_ff @(posedge clk) begin
		if (en[6]) begin
			rnum_s7  <= rnum_d;
			gnum_s7  <= gnum_d;
			bnum_s7  <= bnum_d;
			tot_s7   <= tot_d;
			alpha_s7 <= anum_d[4 +: CH_W];
		end
		if (en[7]) begin
			argb_s8 <= (tot_s7 == '0) ? '0 : {alpha_s7, rq_d, gq_d, bq_d};
		end
	end

	`SSCP_ASSERT_IMP(a_ready_full, clk, arst_n, !s_tready, &vld_q)
	`SSCP_ASSERT_IMP(a_alpha_zero, clk, arst_n, m_tvalid,
		(m_tdata[31:24] == 8'd0) == (m_tdata == '0))
	`SSCP_ASSERT_IMP(a_size_sq, clk, arst_n, 1'b1,
		(nsq_q == NSQ_W'(size_q * size_q)) && (size_q >= SIZE_W'(MIN_SIZE))
		&& (size_q <= SIZE_W'(MAX_SIZE)))
	`SSCP_ASSERT_NXT(a_hold_out, clk, arst_n, m_tvalid && !m_tready && !cfg_we,
		m_tvalid && $stable(m_tdata))

endmodule
`default_nettype wire

@@ rtl/sscp_cover.sv @@
`timescale 1ns / 1ps
`default_nettype none
module sscp_cover (
	input  wire logic                         clk,
	input  wire sscp_pkg::cov_ctl_t           ctl,
	input  wire logic [sscp_pkg::COORD_W-1:0] pixel_x,
	input  wire logic [sscp_pkg::COORD_W-1:0] pixel_y,
	input  wire logic [sscp_pkg::SIZE_W-1:0]  size_q,
	input  wire logic [sscp_pkg::NSQ_W-1:0]   nsq_q,
	output logic      [sscp_pkg::CNT_W-1:0]   nl_s6,
	output logic      [sscp_pkg::CNT_W-1:0]   nr_s6
);
	import sscp_pkg::*;

	logic signed [D_W-1:0]   dx_s1 [SUBS];
	logic signed [D_W-1:0]   dy_s1 [SUBS];
	logic [SUBS-1:0]         left_s1, left_s2, left_s3, left_s4;
	logic [LIM_W-1:0]        lim_s1, lim_s2, lim_s3, lim_s4;
	logic [SQ_W-1:0]         dx2_s2 [SUBS];
	logic [SQ_W-1:0]         dy2_s2 [SUBS];
	logic [SUM_W-1:0]        sum_s3 [NSAMP];
	logic [PROD_W-1:0]       prod_s4 [NSAMP];
	logic [NSAMP-1:0]        inl_s5, inr_s5;

	logic signed [D_W-1:0]   dx_d [SUBS];
	logic signed [D_W-1:0]   dy_d [SUBS];
	logic [SQ_W-1:0]         dx2_d [SUBS];
	logic [SQ_W-1:0]         dy2_d [SUBS];
	logic [FINE_W-1:0]       centre;
	logic [LIM_W-1:0]        lim_d;
	logic [CNT_W-1:0]        nl_d, nr_d;

	always_comb begin
		logic [FINE_W-1:0]       fx, fy;
		logic signed [2*D_W-1:0] px2, py2;
		centre = {size_q, 2'b00};
		lim_d  = LIM_W'(nsq_q * LIM_W'(LIMIT_K));
		for (int i = 0; i < SUBS; i++) begin
			fx = FINE_W'({pixel_x, 3'b000}) + FINE_W'(2 * i + 1);
			fy = FINE_W'({pixel_y, 3'b000}) + FINE_W'(2 * i + 1);
			dx_d[i] = $signed({1'b0, fx}) - $signed({1'b0, centre});
			dy_d[i] = $signed({1'b0, fy}) - $signed({1'b0, centre});
			px2 = dx_s1[i] * dx_s1[i];
			py2 = dy_s1[i] * dy_s1[i];
			dx2_d[i] = px2[SQ_W-1:0];
			dy2_d[i] = py2[SQ_W-1:0];
		end
	end

	always_comb begin
		nl_d = '0;
		nr_d = '0;
		for (int k = 0; k < NSAMP; k++) begin
			nl_d = nl_d + CNT_W'(inl_s5[k]);
			nr_d = nr_d + CNT_W'(inr_s5[k]);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.adv[0]) begin
			for (int i = 0; i < SUBS; i++) begin
				dx_s1[i]   <= dx_d[i];
				dy_s1[i]   <= dy_d[i];
				left_s1[i] <= dx_d[i][D_W-1];
			end
			lim_s1 <= lim_d;
		end
		if (ctl.adv[1]) begin
			for (int i = 0; i < SUBS; i++) begin
				dx2_s2[i] <= dx2_d[i];
				dy2_s2[i] <= dy2_d[i];
			end
			left_s2 <= left_s1;
			lim_s2  <= lim_s1;
		end
		if (ctl.adv[2]) begin
			for (int sy = 0; sy < SUBS; sy++) begin
				for (int sx = 0; sx < SUBS; sx++) begin
					sum_s3[sy * SUBS + sx] <= SUM_W'(dx2_s2[sx]) + SUM_W'(dy2_s2[sy]);
				end
			end
			left_s3 <= left_s2;
			lim_s3  <= lim_s2;
		end
		if (ctl.adv[3]) begin
			for (int k = 0; k < NSAMP; k++) begin
				prod_s4[k] <= PROD_W'(sum_s3[k]) * PROD_W'(AREA_K);
			end
			left_s4 <= left_s3;
			lim_s4  <= lim_s3;
		end
		if (ctl.adv[4]) begin
			for (int sy = 0; sy < SUBS; sy++) begin
				for (int sx = 0; sx < SUBS; sx++) begin
					inl_s5[sy * SUBS + sx] <= (prod_s4[sy * SUBS + sx] <= PROD_W'(lim_s4))
						&& left_s4[sx];
					inr_s5[sy * SUBS + sx] <= (prod_s4[sy * SUBS + sx] <= PROD_W'(lim_s4))
						&& !left_s4[sx];
				end
			end
		end
		if (ctl.adv[5]) begin
			nl_s6 <= nl_d;
			nr_s6 <= nr_d;
		end
	end

endmodule
`default_nettype wire

@@ tb/sv/tb_circle_pixel_checker.sv @@
`timescale 1ns / 1ps
module tb_circle_pixel_checker
	import sscp_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic                cfg_index,
	input  wire logic [SIZE_W-1:0]   cfg_data,
	input  wire logic                s_tvalid,
	input  wire logic                s_tready,
	// pixel_x [7:0], pixel_y [15:8]
	input  wire logic [15:0]         s_tdata,
	input  wire logic                m_tvalid,
	input  wire logic                m_tready,
	// argb [31:0]
	input  wire logic [ARGB_W-1:0]   m_tdata,
	output int                       mismatches,
	output int                       in_flight,
	output int                       pixels_checked
);

	localparam int SUB      = 4;
	localparam int SIZE_LO  = 4;
	localparam int SIZE_HI  = 256;

	localparam rgb_t LEFT_ON   = '{r: 8'd0,   g: 8'd120, b: 8'd215};
	localparam rgb_t RIGHT_ON  = '{r: 8'd250, g: 8'd250, b: 8'd250};
	localparam rgb_t LEFT_OFF  = '{r: 8'd110, g: 8'd110, b: 8'd110};
	localparam rgb_t RIGHT_OFF = '{r: 8'd175, g: 8'd175, b: 8'd175};

	typedef struct {
		logic [7:0]        x;
		logic [7:0]        y;
		logic [ARGB_W-1:0] argb;
	} pixel_due_t;

	logic [SIZE_W-1:0] img_n;
	logic              palette_on;
	pixel_due_t        argb_due_q[$];

	function automatic logic [ARGB_W-1:0] circle_pixel_argb(input logic [7:0] px,
			input logic [7:0] py, input logic [SIZE_W-1:0] n_px, input logic pal_on);
		longint n, center, lim, fx, fy, dx, dy;
		int nl, nr, tot, rr, gg, bb, aa;
		rgb_t lc, rc;
		n = longint'(n_px);
		center = SUB * n;
		lim = 529 * SUB * SUB * n * n;
		nl = 0;
		nr = 0;
		for (int sy = 0; sy < SUB; sy++) begin
			fy = 2 * SUB * longint'(py) + 2 * sy + 1;
			dy = fy - center;
			for (int sx = 0; sx < SUB; sx++) begin
				fx = 2 * SUB * longint'(px) + 2 * sx + 1;
				dx = fx - center;
				if (625 * (dx * dx + dy * dy) <= lim) begin
					if (fx < center)
						nl++;
					else
						nr++;
				end
			end
		end
		tot = nl + nr;
		if (tot == 0)
			return '0;
		lc = pal_on ? LEFT_ON : LEFT_OFF;
		rc = pal_on ? RIGHT_ON : RIGHT_OFF;
		rr = (int'(lc.r) * nl + int'(rc.r) * nr) / tot;
		gg = (int'(lc.g) * nl + int'(rc.g) * nr) / tot;
		bb = (int'(lc.b) * nl + int'(rc.b) * nr) / tot;
		aa = (255 * tot) / (SUB * SUB);
		return {8'(aa), 8'(rr), 8'(gg), 8'(bb)};
	endfunction

	always @(posedge clk or negedge arst_n) begin
		pixel_due_t due;
		if (!arst_n) begin
			img_n <= 9'd16;
			palette_on <= 1'b1;
			argb_due_q.delete();
			in_flight <= 0;
			mismatches = 0;
			pixels_checked = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_IMAGE_SIZE) begin
					if (cfg_data < SIZE_LO)
						img_n <= SIZE_W'(SIZE_LO);
					else if (cfg_data > SIZE_HI)
						img_n <= SIZE_W'(SIZE_HI);
					else
						img_n <= cfg_data;
				end else if (cfg_index == REG_ENABLED) begin
					palette_on <= cfg_data[0];
				end
			end
			if (m_tvalid && m_tready) begin
				if (argb_due_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("[%0t] unexpected result argb=%08h", $realtime, m_tdata);
				end else begin
					due = argb_due_q.pop_front();
					pixels_checked++;
					if (m_tdata !== due.argb) begin
						mismatches++;
						if (mismatches <= 10)
							$display("[%0t] pixel (%0d,%0d) size %0d: expected argb=%08h got %08h",
								$realtime, due.x, due.y, img_n, due.argb, m_tdata);
					end
				end
			end
			if (s_tvalid && s_tready) begin
				due.x = s_tdata[7:0];
				due.y = s_tdata[15:8];
				due.argb = circle_pixel_argb(s_tdata[7:0], s_tdata[15:8], img_n, palette_on);
				argb_due_q.push_back(due);
			end
			in_flight <= argb_due_q.size();
		end
	end

endmodule

@@ tb/sv/tb_supersampled_split_circle_pixel_unit.sv @@
`timescale 1ns / 1ps
module tb_supersampled_split_circle_pixel_unit;
	import sscp_pkg::*;

	localparam int NUM_PHASES  = 10;
	localparam int PHASE_ITEMS = 108;
	localparam int PRESS_PHASE = 4;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 20;

	// directed pixels as {x, y}
	localparam logic [15:0] PTS_RESET [15] = '{
		{8'd0, 8'd0}, {8'd255, 8'd255}, {8'd0, 8'd255}, {8'd255, 8'd0},
		{8'd7, 8'd7}, {8'd8, 8'd8}, {8'd7, 8'd8}, {8'd8, 8'd7},
		{8'd0, 8'd8}, {8'd15, 8'd8}, {8'd8, 8'd0}, {8'd1, 8'd1},
		{8'd20, 8'd4}, {8'd16, 8'd16}, {8'd170, 8'd85}
	};
	localparam logic [15:0] PTS_TINY [5] = '{
		{8'd0, 8'd0}, {8'd1, 8'd1}, {8'd1, 8'd2}, {8'd3, 8'd3}, {8'd2, 8'd1}
	};
	localparam logic [15:0] PTS_HUGE [5] = '{
		{8'd0, 8'd0}, {8'd127, 8'd127}, {8'd128, 8'd128}, {8'd255, 8'd255},
		{8'd0, 8'd128}
	};

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic                 cfg_index = 1'b0;
	logic [SIZE_W-1:0]    cfg_data = '0;
	logic                 s_tvalid = 1'b0;
	logic [15:0]          s_tdata = '0;
	logic                 m_tready = 1'b0;
	wire logic            s_tready;
	wire logic            m_tvalid;
	wire logic [ARGB_W-1:0] m_tdata;

	int mismatches;
	int in_flight;
	int pixels_checked;
	int settings_used = 1;
	bit hold_req = 1'b0;
	bit hold_done = 1'b0;

	always #5 clk = ~clk;

	supersampled_split_circle_pixel_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	tb_circle_pixel_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.mismatches    (mismatches),
		.in_flight     (in_flight),
		.pixels_checked(pixels_checked)
	);

	task automatic send_pixel(input logic [7:0] x, input logic [7:0] y, input bit burst);
		int gap;
		int r;
		s_tdata <= {y, x};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		r = $urandom_range(0, 99);
		if (burst || r < 55)
			gap = 0;
		else if (r < 90)
			gap = $urandom_range(1, 4);
		else
			gap = $urandom_range(8, 40);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// drain the pipeline, then write both registers
	task automatic set_regs(input logic [SIZE_W-1:0] size_raw, input logic en);
		s_tvalid <= 1'b0;
		do @(posedge clk); while (in_flight != 0);
		repeat (2) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_IMAGE_SIZE;
		cfg_data <= size_raw;
		@(posedge clk);
		cfg_index <= REG_ENABLED;
		cfg_data <= {8'($urandom), en};
		@(posedge clk);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	initial begin
		int rx_len;
		int r;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req && !hold_done) begin
				m_tready <= 1'b0;
				rx_len = HOLD_CYCLES;
				hold_done = 1'b1;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 45) begin
					m_tready <= 1'b1;
					rx_len = $urandom_range(1, 40);
				end else if (r < 90) begin
					m_tready <= 1'b0;
					rx_len = $urandom_range(1, 3);
				end else begin
					m_tready <= 1'b0;
					rx_len = $urandom_range(10, 40);
				end
			end
			repeat (rx_len) @(posedge clk);
		end
	end

	initial begin
		#(5_000_000);
		$display("supersampled_split_circle_pixel_unit regression: fail");
		$finish;
	end

	initial begin
		logic [SIZE_W-1:0] size_raw;
		logic              en;
		int                n_eff;
		logic [7:0]        x;
		logic [7:0]        y;
		bit                burst;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (PTS_RESET[i])
			send_pixel(PTS_RESET[i][15:8], PTS_RESET[i][7:0], 1'b0);
		set_regs(9'd3, 1'b0);
		foreach (PTS_TINY[i])
			send_pixel(PTS_TINY[i][15:8], PTS_TINY[i][7:0], 1'b0);
		set_regs(9'd511, 1'b1);
		foreach (PTS_HUGE[i])
			send_pixel(PTS_HUGE[i][15:8], PTS_HUGE[i][7:0], 1'b0);

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			en = 1'($urandom);
			case (ph)
				0: size_raw = 9'd4;
				1: begin size_raw = 9'd256; en = 1'b0; end
				2: size_raw = 9'd0;
				3: begin size_raw = 9'd257; en = 1'b1; end
				PRESS_PHASE: size_raw = 9'd256;
				default: begin
					r_pick: begin
						int r;
						r = $urandom_range(0, 3);
						if (r == 0)
							size_raw = 9'($urandom);
						else if (r == 1)
							size_raw = 9'($urandom_range(4, 12));
						else
							size_raw = 9'($urandom_range(4, 256));
					end
				end
			endcase
			set_regs(size_raw, en);
			n_eff = (size_raw < 4) ? 4 : (size_raw > 256) ? 256 : int'(size_raw);
			burst = (ph == PRESS_PHASE) || ($urandom_range(0, 3) == 0);
			if (ph == PRESS_PHASE)
				hold_req = 1'b1;
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if ($urandom_range(0, 4) == 0) begin
					x = 8'($urandom);
					y = 8'($urandom);
				end else begin
					x = 8'($urandom_range(0, n_eff - 1));
					y = 8'($urandom_range(0, n_eff - 1));
				end
				send_pixel(x, y, burst);
			end
		end

		s_tvalid <= 1'b0;
		do @(posedge clk); while (in_flight != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("checked %0d pixel results over %0d register settings, sizes 4 to 256, both palettes",
			pixels_checked, settings_used);
		$display("output held off once for %0d cycles while pixels kept arriving", HOLD_CYCLES);
		if (mismatches == 0 && in_flight == 0)
			$display("supersampled_split_circle_pixel_unit regression: pass");
		else
			$display("supersampled_split_circle_pixel_unit regression: fail");
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/sscp_pkg.sv
rtl/sscp_cover.sv
rtl/supersampled_split_circle_pixel_unit.sv
tb/sv/tb_circle_pixel_checker.sv
tb/sv/tb_supersampled_split_circle_pixel_unit.sv
